// ===== rtl/pcl_pkg.sv =====
// pcl_pkg: shared types, register reset values and display tables for the
// pelican crossing light controller; no dependencies
package pcl_pkg;

   localparam int TIMER_WIDTH_DEFAULT = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 16;

   // register reset values
   localparam logic [15:0] MIN_GREEN_RESET   = 16'd4000;
   localparam logic [15:0] PRESS_DELAY_RESET = 16'd8000;
   localparam logic [15:0] YELLOW_RESET      = 16'd2500;
   localparam logic [15:0] WALK_RESET        = 16'd5000;
   localparam logic [15:0] COUNT_STEP_RESET  = 16'd1000;
   localparam logic [11:0] FRAME_RESET       = 12'd150;
   localparam logic [3:0]  COUNT_START_RESET = 4'd9;

   localparam logic [3:0] DIGIT_MAX = 4'd9;
   localparam logic [3:0] READY_DIGIT = 4'd5;

   // lamp codes
   localparam logic [2:0] CAR_RED    = 3'b001;
   localparam logic [2:0] CAR_YELLOW = 3'b010;
   localparam logic [2:0] CAR_GREEN  = 3'b100;
   localparam logic [1:0] WALKER_DONT_WALK = 2'b01;
   localparam logic [1:0] WALKER_WALK      = 2'b10;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MIN_GREEN   = 3'd0,
      CSR_PRESS_DELAY = 3'd1,
      CSR_YELLOW      = 3'd2,
      CSR_WALK        = 3'd3,
      CSR_COUNT_STEP  = 3'd4,
      CSR_FRAME       = 3'd5,
      CSR_COUNT_START = 3'd6
   } csr_reg_type;

   typedef enum logic [4:0] {
      PH_READY  = 5'b00001,
      PH_WAIT   = 5'b00010,
      PH_YELLOW = 5'b00100,
      PH_WALK   = 5'b01000,
      PH_COUNT  = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [15:0] min_green_ms;
      logic [15:0] press_delay_ms;
      logic [15:0] yellow_ms;
      logic [15:0] walk_ms;
      logic [15:0] count_step_ms;
      logic [11:0] frame_ms;
      logic [3:0]  count_start;
   } cfg_type;

   typedef struct packed {
      logic [2:0] car_lamps;
      logic [1:0] walker_lamps;
      logic [6:0] segments;
   } result_type;

   // seven segment pattern of a digit, values above nine show nine
   function automatic logic [6:0] digit_segs(input logic [3:0] digit);
      logic [6:0] segs;
      unique case (digit)
         4'd0:    segs = 7'h3F;
         4'd1:    segs = 7'h09;
         4'd2:    segs = 7'h5E;
         4'd3:    segs = 7'h5B;
         4'd4:    segs = 7'h69;
         4'd5:    segs = 7'h73;
         4'd6:    segs = 7'h77;
         4'd7:    segs = 7'h19;
         4'd8:    segs = 7'h7F;
         default: segs = 7'h7B;
      endcase
      return segs;
   endfunction

   // chase animation: line 1, line 6, line 4, blank
   function automatic logic [6:0] frame_segs(input logic [1:0] frame);
      logic [6:0] segs;
      unique case (frame)
         2'd0:    segs = 7'h02;
         2'd1:    segs = 7'h40;
         2'd2:    segs = 7'h10;
         default: segs = 7'h00;
      endcase
      return segs;
   endfunction

endpackage

// ===== rtl/pedestrian_crossing_light_controller.sv =====
// pedestrian_crossing_light_controller: top level of the pelican crossing controller
// instantiates pcl_csr and pcl_fsm, depends on pcl_pkg
//
// usage
// - request channel (req_valid/req_ready/req_button): one transaction per
//   millisecond tick, carrying the sampled button level
// - response channel (rsp_valid/rsp_ready/rsp_*): one transaction per tick
//   with the car lamps, walker lamps and seven segment drives after that tick
// - csr channel (csr_valid/csr_ready/csr_index/csr_wdata): register writes,
//   always ready; write only while no tick is in flight
// - path: an accepted request is held in the input register, then the state
//   update writes its result into the response register, which raises rsp_valid
// - throughput: one tick per clock while the receiver does not stall, set by the
//   combinational state update between the input register and the response register
// - reset: phase goes to ready (cars green, don't walk, display 5), all
//   timers clear and the registers take their default timings
// - receiver stall: the response register holds; the input register still
//   takes one more tick, then req_ready drops until the response drains
module pedestrian_crossing_light_controller #(
   parameter int TIMER_WIDTH = pcl_pkg::TIMER_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_button,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [2:0]                       rsp_car_lamps,
   output logic [1:0]                       rsp_walker_lamps,
   output logic [6:0]                       rsp_segments,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [pcl_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [pcl_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import pcl_pkg::*;

   cfg_type    cfg;
   result_type result;

   // input register
   logic s1_valid_ff, s1_valid_in;
   logic s1_button_ff;
   // response register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;

   logic step_en;
   logic req_take;

   // tick moves into the response register when it is empty or draining
   assign step_en = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || step_en;
   assign req_take = req_valid && req_ready;

   always_comb begin
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (step_en) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (step_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_button_ff <= req_button;
      end
      if (step_en) begin
         rsp_ff <= result;
      end
   end

   pcl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pcl_fsm #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_fsm (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .button  (s1_button_ff),
      .cfg     (cfg),
      .result  (result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_car_lamps = rsp_ff.car_lamps;
   assign rsp_walker_lamps = rsp_ff.walker_lamps;
   assign rsp_segments = rsp_ff.segments;

endmodule

// ===== rtl/pcl_csr.sv =====
// pcl_csr: configuration register file of the crossing controller
// depends on pcl_pkg
module pcl_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pcl_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pcl_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output pcl_pkg::cfg_type                   cfg
);
   import pcl_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_reg_type'(csr_index))
            CSR_MIN_GREEN:   cfg_in.min_green_ms   = csr_wdata;
            CSR_PRESS_DELAY: cfg_in.press_delay_ms = csr_wdata;
            CSR_YELLOW:      cfg_in.yellow_ms      = csr_wdata;
            CSR_WALK:        cfg_in.walk_ms        = csr_wdata;
            CSR_COUNT_STEP:  cfg_in.count_step_ms  = csr_wdata;
            CSR_FRAME:       cfg_in.frame_ms       = csr_wdata[11:0];
            CSR_COUNT_START: cfg_in.count_start    = csr_wdata[3:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_green_ms   <= MIN_GREEN_RESET;
         cfg_ff.press_delay_ms <= PRESS_DELAY_RESET;
         cfg_ff.yellow_ms      <= YELLOW_RESET;
         cfg_ff.walk_ms        <= WALK_RESET;
         cfg_ff.count_step_ms  <= COUNT_STEP_RESET;
         cfg_ff.frame_ms       <= FRAME_RESET;
         cfg_ff.count_start    <= COUNT_START_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/pcl_fsm.sv =====
// pcl_fsm: phase state machine, timers and lamp/display decode, one tick per step
// depends on pcl_pkg
module pcl_fsm #(
   parameter int TIMER_WIDTH = pcl_pkg::TIMER_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  logic                 button,
   input  pcl_pkg::cfg_type     cfg,
   output pcl_pkg::result_type  result
);
   import pcl_pkg::*;

   localparam int CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
   localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;

   phase_type              phase_ff, phase_in;
   logic [TIMER_WIDTH-1:0] phase_timer_ff, phase_timer_in;
   logic [15:0]            green_elapsed_ff, green_elapsed_in;
   logic [15:0]            wait_length_ff, wait_length_in;
   logic [3:0]             count_digit_ff, count_digit_in;
   logic [1:0]             anim_frame_ff, anim_frame_in;
   logic [11:0]            frame_timer_ff, frame_timer_in;

   logic [15:0]            cap;
   logic [15:0]            green_clamped;
   logic [15:0]            wait_calc;
   logic [TIMER_WIDTH-1:0] timer_inc;
   logic [CMP_W-1:0]       timer_cmp;
   logic [11:0]            frame_inc;
   logic [1:0]             anim_inc;
   logic [3:0]             start_digit;

   always_comb begin
      cap = (cfg.min_green_ms == 16'd0) ? 16'd0 : cfg.min_green_ms - 16'd1;
      green_clamped = (green_elapsed_ff > cap) ? cap : green_elapsed_ff;
      wait_calc = (cfg.press_delay_ms > green_clamped) ?
                  cfg.press_delay_ms - green_clamped : 16'd0;
      timer_inc = (phase_timer_ff == TIMER_MAX) ? TIMER_MAX : phase_timer_ff + 1'b1;
      timer_cmp = CMP_W'(timer_inc);
      frame_inc = frame_timer_ff + 12'd1;
      anim_inc = anim_frame_ff + 2'd1;
      if (cfg.count_start == 4'd0) begin
         start_digit = 4'd1;
      end else if (cfg.count_start > DIGIT_MAX) begin
         start_digit = DIGIT_MAX;
      end else begin
         start_digit = cfg.count_start;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      phase_timer_in = phase_timer_ff;
      green_elapsed_in = green_clamped;
      wait_length_in = wait_length_ff;
      count_digit_in = count_digit_ff;
      anim_frame_in = anim_frame_ff;
      frame_timer_in = frame_timer_ff;
      unique case (phase_ff)
         PH_WAIT: begin
            phase_timer_in = timer_inc;
            if (timer_cmp >= CMP_W'(wait_length_ff)) begin
               phase_in = PH_YELLOW;
               phase_timer_in = '0;
            end
         end
         PH_YELLOW: begin
            phase_timer_in = timer_inc;
            if (timer_cmp >= CMP_W'(cfg.yellow_ms)) begin
               phase_in = PH_WALK;
               phase_timer_in = '0;
               anim_frame_in = 2'd0;
               frame_timer_in = 12'd0;
            end
         end
         PH_WALK: begin
            phase_timer_in = timer_inc;
            frame_timer_in = frame_inc;
            if (frame_inc >= cfg.frame_ms || frame_inc == 12'd0) begin
               frame_timer_in = 12'd0;
               anim_frame_in = anim_inc;
               // walk ends only at the end of a whole round
               if (anim_inc == 2'd0 && timer_cmp >= CMP_W'(cfg.walk_ms)) begin
                  phase_in = PH_COUNT;
                  phase_timer_in = '0;
                  count_digit_in = start_digit;
               end
            end
         end
         PH_COUNT: begin
            phase_timer_in = timer_inc;
            if (timer_cmp >= CMP_W'(cfg.count_step_ms)) begin
               phase_timer_in = '0;
               if (count_digit_ff <= 4'd1) begin
                  phase_in = PH_READY;
                  count_digit_in = 4'd0;
                  green_elapsed_in = 16'd0;
               end else begin
                  count_digit_in = count_digit_ff - 4'd1;
               end
            end
         end
         default: begin
            phase_in = PH_READY;
            if (button) begin
               wait_length_in = wait_calc;
               phase_timer_in = '0;
               // no wait left: straight to yellow on the press tick
               phase_in = (wait_calc == 16'd0) ? PH_YELLOW : PH_WAIT;
            end else if (green_clamped < cap) begin
               green_elapsed_in = green_clamped + 16'd1;
            end
         end
      endcase
   end

   // result shows the phase after this tick's update
   always_comb begin
      unique case (phase_in)
         PH_YELLOW: begin
            result.car_lamps = CAR_YELLOW;
            result.walker_lamps = WALKER_DONT_WALK;
            result.segments = digit_segs(READY_DIGIT);
         end
         PH_WALK: begin
            result.car_lamps = CAR_RED;
            result.walker_lamps = WALKER_WALK;
            result.segments = frame_segs(anim_frame_in);
         end
         PH_COUNT: begin
            result.car_lamps = CAR_RED;
            result.walker_lamps = WALKER_WALK;
            result.segments = digit_segs(count_digit_in);
         end
         default: begin
            result.car_lamps = CAR_GREEN;
            result.walker_lamps = WALKER_DONT_WALK;
            result.segments = digit_segs(READY_DIGIT);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_READY;
         phase_timer_ff <= '0;
         green_elapsed_ff <= 16'd0;
         wait_length_ff <= 16'd0;
         count_digit_ff <= 4'd0;
         anim_frame_ff <= 2'd0;
         frame_timer_ff <= 12'd0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         phase_timer_ff <= phase_timer_in;
         green_elapsed_ff <= green_elapsed_in;
         wait_length_ff <= wait_length_in;
         count_digit_ff <= count_digit_in;
         anim_frame_ff <= anim_frame_in;
         frame_timer_ff <= frame_timer_in;
      end
   end

endmodule

// ===== rtl/pcl_checker.sv =====
// pcl_checker: port-level checks of the crossing controller, bound to the top level
// depends on pcl_pkg
module pcl_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [2:0]                       rsp_car_lamps,
   input logic [1:0]                       rsp_walker_lamps,
   input logic [6:0]                       rsp_segments
);
   import pcl_pkg::*;

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_car_lamps) &&
      $stable(rsp_walker_lamps) && $stable(rsp_segments))
      else $error("stalled response changed");

   // exactly one car lamp lit
   a_one_car_lamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot(rsp_car_lamps))
      else $error("car lamps not one-hot");

   // walk only while cars see red, and the other way round
   a_walk_red: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_car_lamps == CAR_RED) == (rsp_walker_lamps == WALKER_WALK)))
      else $error("walk lamp and car red disagree");

   // reset empties the response stage
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // with a draining receiver the request side never stalls
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_ready && !$past(reset) && $past(rsp_ready) |-> req_ready)
      else $error("request stalled with open response side");

endmodule

bind pedestrian_crossing_light_controller pcl_checker u_pcl_checker (.*);
